/* hdl/mngc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mngc_pkg
// Shared types and constants of the MIDI note to gate converter: the layout
// of one stored gate entry, the decoded sweep operation and register codes.
// ----------------------------------------------------------------------------
package mngc_pkg;

    localparam int GATE_COUNT_DEF    = 16;
    localparam int CHANNEL_COUNT_DEF = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_NOTE_MAP_0_3   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NOTE_MAP_4_7   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_NOTE_MAP_8_11  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_NOTE_MAP_12_15 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_VELOCITY_MODE  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MPE_MODE       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_TRIG_MODE      = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_PULSE_TICKS    = 3'd7;

    // Register reset values.
    localparam logic [31:0] NOTE_MAP_0_3_RST   = 32'd858927408;
    localparam logic [31:0] NOTE_MAP_4_7_RST   = 32'd791555372;
    localparam logic [31:0] NOTE_MAP_8_11_RST  = 32'd724183336;
    localparam logic [31:0] NOTE_MAP_12_15_RST = 32'd656811300;
    localparam logic [15:0] PULSE_TICKS_RST    = 16'd48;

    // Velocity modes.
    localparam logic [1:0] VM_FIXED    = 2'd0;
    localparam logic [1:0] VM_NOTE_VEL = 2'd1;
    localparam logic [1:0] VM_PRESSURE = 2'd2;

    // MIDI message kinds (high nibble of the status byte).
    localparam logic [3:0] KIND_NOTE_OFF    = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON     = 4'h9;
    localparam logic [3:0] KIND_AFTERTOUCH  = 4'hA;
    localparam logic [3:0] KIND_PRESSURE    = 4'hD;

    localparam logic [6:0] LEVEL_FULL = 7'h7f;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_NOTE_ON,
        OP_NOTE_OFF,
        OP_AFTERTOUCH,
        OP_PRESSURE,
        OP_TICK
    } op_code_t;

    // One decoded item, applied to every gate of one channel.
    typedef struct packed {
        op_code_t   code;
        logic [6:0] note;
        logic [6:0] value;
    } sweep_op_t;

    // Mode registers the gate unit needs.
    typedef struct packed {
        logic [1:0]  velocity_mode;
        logic        trig_mode;
        logic [15:0] pulse_ticks;
    } gate_cfg_t;

    // One stored gate of one channel.
    typedef struct packed {
        logic        open;
        logic [6:0]  vel;
        logic [15:0] pulse;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{open: 1'b0, vel: 7'h7f, pulse: 16'd0};

endpackage : mngc_pkg
`default_nettype wire

/* hdl/mngc_gate_alu.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mngc_gate_alu
// Shared update unit: applies one decoded operation to one gate entry and
// produces the new entry and the level reported on a tick.
// ----------------------------------------------------------------------------
module mngc_gate_alu (
    input  mngc_pkg::sweep_op_t op,
    input  mngc_pkg::gate_cfg_t cfg,
    input  logic [7:0]          learned,
    input  mngc_pkg::entry_t    entry_in,
    output mngc_pkg::entry_t    entry_out,
    output logic [6:0]          level
);
    import mngc_pkg::*;

    logic match;
    logic pulse_nz;
    logic high;

    // A learned byte above 127 never matches any note.
    assign match    = (learned[7] == 1'b0) && (learned[6:0] == op.note);
    assign pulse_nz = (entry_in.pulse != 16'd0);

    always_comb
    begin
        entry_out = entry_in;
        high      = 1'b0;
        unique case (op.code)
            OP_NOTE_ON:
            begin
                if (match)
                begin
                    entry_out.open = 1'b1;
                    if (cfg.velocity_mode == VM_NOTE_VEL)
                        entry_out.vel = op.value;
                    entry_out.pulse = cfg.pulse_ticks;
                end
            end
            OP_NOTE_OFF:
            begin
                if (match)
                    entry_out.open = 1'b0;
            end
            OP_AFTERTOUCH:
            begin
                if (match && (cfg.velocity_mode == VM_PRESSURE))
                    entry_out.vel = op.value;
            end
            OP_PRESSURE:
            begin
                if (cfg.velocity_mode == VM_PRESSURE)
                    entry_out.vel = op.value;
            end
            OP_TICK:
            begin
                if (pulse_nz)
                    entry_out.pulse = entry_in.pulse - 16'd1;
                high = pulse_nz || (!cfg.trig_mode && entry_in.open);
            end
            default:
            begin
                entry_out = entry_in;
            end
        endcase
    end

    assign level = !high ? 7'd0
                 : (cfg.velocity_mode == VM_FIXED) ? LEVEL_FULL : entry_in.vel;

endmodule : mngc_gate_alu
`default_nettype wire

/* hdl/midi_note_to_gate_converter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// midi_note_to_gate_converter
// Turns MIDI note messages into gate levels for up to sixteen gates on up to
// sixteen polyphonic channels, with trigger pulses and velocity tracking.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) carries one item: either a MIDI
//   message (cmd = 0) or a sample tick for one channel (cmd = 1). The output
//   channel (out_valid / out_stall) carries the levels. A message yields no
//   result; a tick yields GATE_COUNT results, gate 0 first, with last set on
//   the final one. Ignored items (short messages, channels that do not exist)
//   are taken without a sweep and produce nothing.
//   Each accepted item is swept over all gates by one shared update unit, one
//   gate per cycle while the receiver does not stall, reading and writing the
//   gate memory through one read and one write port. The first level of a
//   tick passes the memory read register and the update unit before it is
//   registered in the output register. in_stall is high while the sweep runs.
//   A stalled output item is held in the output register; the sweep pauses
//   until it is taken, and a following item may be accepted while the last
//   level still waits.
//   Reset clears all gates through per-entry valid bits, so no clearing pass
//   is needed and the block takes items right after reset. Configuration is
//   written through cfg_wr_en / cfg_index / cfg_data while the block is idle.
// ----------------------------------------------------------------------------
module midi_note_to_gate_converter #(
    parameter int GATE_COUNT    = mngc_pkg::GATE_COUNT_DEF,
    parameter int CHANNEL_COUNT = mngc_pkg::CHANNEL_COUNT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write port.
    input  logic                             cfg_wr_en,
    input  logic [mngc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mngc_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Input channel.
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             cmd,
    input  logic [1:0]                       msg_size,
    input  logic [7:0]                       status_byte,
    input  logic [7:0]                       data_one,
    input  logic [7:0]                       data_two,
    input  logic [3:0]                       tick_channel,
    // Output channel.
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [3:0]                       gate_index,
    output logic [3:0]                       out_channel,
    output logic [6:0]                       level,
    output logic                             last
);
    import mngc_pkg::*;

    localparam int DEPTH  = GATE_COUNT * CHANNEL_COUNT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [4:0] GATE_LIM    = 5'(GATE_COUNT);
    localparam logic [3:0] GATE_LAST   = 4'(GATE_COUNT - 1);
    localparam logic [4:0] CHANNEL_LIM = 5'(CHANNEL_COUNT);

    typedef enum logic {
        ST_IDLE,
        ST_SWEEP
    } state_t;

    // Configuration registers.
    logic [31:0] note_map_reg [4];
    logic [1:0]  velocity_mode_reg;
    logic        mpe_mode_reg;
    logic        trig_mode_reg;
    logic [15:0] pulse_ticks_reg;

    // Sequencer.
    state_t      state_reg;
    sweep_op_t   op_reg;
    logic [3:0]  chan_reg;
    logic [4:0]  issue_gate_reg;
    logic [3:0]  proc_gate_reg;
    logic        proc_valid_reg;

    // Output register.
    logic        out_valid_reg;
    logic [3:0]  gate_index_reg;
    logic [3:0]  out_channel_reg;
    logic [6:0]  level_reg;
    logic        last_reg;

    // Gate memory with per-entry valid bits.
    entry_t             mem [DEPTH];
    entry_t             rd_data_reg;
    logic               rd_hit_reg;
    logic [DEPTH-1:0]   valid_reg;

    logic               in_take;
    logic               slot_free;
    logic               proceed;
    logic               issue;
    logic               sweep_done;
    logic [7:0]         rd_addr_full;
    logic [7:0]         wr_addr_full;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    entry_t             cur_entry;
    entry_t             new_entry;
    logic [6:0]         alu_level;
    logic [7:0]         learned;
    gate_cfg_t          gate_cfg;

    // Item decode at accept time.
    sweep_op_t          dec_op;
    logic [3:0]         dec_chan;
    logic               dec_skip;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        dec_op.note  = data_one[6:0];
        dec_op.value = data_two[6:0];
        dec_op.code  = OP_NONE;
        dec_chan     = 4'd0;
        dec_skip     = 1'b0;
        if (cmd)
        begin
            dec_op.code = OP_TICK;
            dec_chan    = tick_channel;
            dec_skip    = ({1'b0, tick_channel} >= CHANNEL_LIM)
                       || (!mpe_mode_reg && (tick_channel != 4'd0));
        end
        else
        begin
            dec_chan = mpe_mode_reg ? status_byte[3:0] : 4'd0;
            priority if ((status_byte[7:4] == KIND_NOTE_ON) && (data_two != 8'd0))
                dec_op.code = OP_NOTE_ON;
            else if ((status_byte[7:4] == KIND_NOTE_ON)
                  || (status_byte[7:4] == KIND_NOTE_OFF))
                dec_op.code = OP_NOTE_OFF;
            else if (status_byte[7:4] == KIND_AFTERTOUCH)
                dec_op.code = OP_AFTERTOUCH;
            else if (status_byte[7:4] == KIND_PRESSURE)
            begin
                dec_op.code  = OP_PRESSURE;
                dec_op.value = data_one[6:0];
            end
            else
                dec_op.code = OP_NONE;
            // Short messages, absent channels and unknown kinds are dropped without a sweep.
            dec_skip = (msg_size < 2'd2) || ({1'b0, dec_chan} >= CHANNEL_LIM)
                    || (dec_op.code == OP_NONE);
        end
    end

    // Sweep control: one gate is read while the previous one is updated.
    assign slot_free  = !out_valid_reg || !out_stall;
    assign proceed    = proc_valid_reg && ((op_reg.code != OP_TICK) || slot_free);
    assign issue      = (state_reg == ST_SWEEP) && (issue_gate_reg < GATE_LIM)
                     && (!proc_valid_reg || proceed);
    assign sweep_done = proceed && (proc_gate_reg == GATE_LAST);

    assign rd_addr_full = 8'(issue_gate_reg[3:0]) * 8'(CHANNEL_COUNT) + 8'(chan_reg);
    assign wr_addr_full = 8'(proc_gate_reg) * 8'(CHANNEL_COUNT) + 8'(chan_reg);
    assign rd_addr      = rd_addr_full[ADDR_W-1:0];
    assign wr_addr      = wr_addr_full[ADDR_W-1:0];

    // An entry never written since reset reads as the reset gate.
    assign cur_entry = rd_hit_reg ? rd_data_reg : ENTRY_RESET;
    assign learned   = note_map_reg[proc_gate_reg[3:2]][{proc_gate_reg[1:0], 3'b000} +: 8];

    assign gate_cfg.velocity_mode = velocity_mode_reg;
    assign gate_cfg.trig_mode     = trig_mode_reg;
    assign gate_cfg.pulse_ticks   = pulse_ticks_reg;

    mngc_gate_alu u_gate_alu (
        .op        (op_reg),
        .cfg       (gate_cfg),
        .learned   (learned),
        .entry_in  (cur_entry),
        .entry_out (new_entry),
        .level     (alu_level)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            note_map_reg[0]   <= NOTE_MAP_0_3_RST;
            note_map_reg[1]   <= NOTE_MAP_4_7_RST;
            note_map_reg[2]   <= NOTE_MAP_8_11_RST;
            note_map_reg[3]   <= NOTE_MAP_12_15_RST;
            velocity_mode_reg <= VM_FIXED;
            mpe_mode_reg      <= 1'b0;
            trig_mode_reg     <= 1'b0;
            pulse_ticks_reg   <= PULSE_TICKS_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_NOTE_MAP_0_3:   note_map_reg[0]   <= cfg_data;
                REG_NOTE_MAP_4_7:   note_map_reg[1]   <= cfg_data;
                REG_NOTE_MAP_8_11:  note_map_reg[2]   <= cfg_data;
                REG_NOTE_MAP_12_15: note_map_reg[3]   <= cfg_data;
                REG_VELOCITY_MODE:  velocity_mode_reg <= cfg_data[1:0];
                REG_MPE_MODE:       mpe_mode_reg      <= cfg_data[0];
                REG_TRIG_MODE:      trig_mode_reg     <= cfg_data[0];
                REG_PULSE_TICKS:    pulse_ticks_reg   <= cfg_data[15:0];
                default:            mpe_mode_reg      <= mpe_mode_reg;
            endcase
        end
    end

    // Sequencer state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            op_reg          <= '{code: OP_NONE, note: 7'd0, value: 7'd0};
            chan_reg        <= 4'd0;
            issue_gate_reg  <= 5'd0;
            proc_gate_reg   <= 4'd0;
            proc_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            gate_index_reg  <= 4'd0;
            out_channel_reg <= 4'd0;
            level_reg       <= 7'd0;
            last_reg        <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_take && !dec_skip)
                    begin
                        state_reg      <= ST_SWEEP;
                        op_reg         <= dec_op;
                        chan_reg       <= dec_chan;
                        issue_gate_reg <= 5'd0;
                        proc_valid_reg <= 1'b0;
                    end
                end
                ST_SWEEP:
                begin
                    if (issue)
                    begin
                        issue_gate_reg <= issue_gate_reg + 5'd1;
                        proc_gate_reg  <= issue_gate_reg[3:0];
                        proc_valid_reg <= 1'b1;
                    end
                    else if (proceed)
                        proc_valid_reg <= 1'b0;
                    if (sweep_done)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (proceed && (op_reg.code == OP_TICK))
            begin
                out_valid_reg   <= 1'b1;
                gate_index_reg  <= proc_gate_reg;
                out_channel_reg <= chan_reg;
                level_reg       <= alu_level;
                last_reg        <= (proc_gate_reg == GATE_LAST);
            end
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Gate memory: one read port, one write port.
    always_ff @(posedge clk)
    begin
        if (issue)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (proceed)
            mem[wr_addr] <= new_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (issue)
                rd_hit_reg <= valid_reg[rd_addr];
            if (proceed)
                valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign out_valid   = out_valid_reg;
    assign gate_index  = gate_index_reg;
    assign out_channel = out_channel_reg;
    assign level       = level_reg;
    assign last        = last_reg;

    // The update stage is empty whenever the block is idle.
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !proc_valid_reg)
        else $error("gate update pending while idle");

    // The memory is written only during a sweep.
    a_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        proceed |-> (state_reg == ST_SWEEP))
        else $error("gate memory written outside a sweep");

    // After the last gate of a tick the block is ready for a new item.
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (proceed && (op_reg.code == OP_TICK) && (proc_gate_reg == GATE_LAST))
        |=> (state_reg == ST_IDLE) && out_valid_reg && last_reg)
        else $error("sweep did not end on the last gate");

    // A new level appears only as the product of a sweep step.
    a_out_from_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_SWEEP))
        else $error("level emitted outside a sweep");

endmodule : midi_note_to_gate_converter
`default_nettype wire

/* verif/tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the MIDI note to gate converter. A small gate
// tracker class mirrors the gate memory and the mode registers, predicts the
// sixteen levels of every tick and compares them with what the block emits.
// Stimulus is a directed pass over the corner cases followed by randomized
// MIDI traffic under several register settings, with random idling on both
// sides, an idle-free stretch and one long output hold.
// ----------------------------------------------------------------------------
module tb;

    import mngc_pkg::*;

    localparam int NUM_GATES    = GATE_COUNT_DEF;
    localparam int NUM_CHANNELS = CHANNEL_COUNT_DEF;

    // After the last level has arrived a message sweep may still be running,
    // so wait a few sweeps.
    localparam int DRAIN_CYCLES = 3 * (NUM_GATES + 2);

    // The limit lies well above the slowest correct run: every tick with
    // sixteen levels, each held by the longest receiver stall, plus sender
    // gaps and the long hold.
    localparam int CYCLE_LIMIT  = 600000;

    // Length of the long output hold that fills the block up.
    localparam int HOLD_CYCLES  = 400;

    // A message kind the block does not act on (control change).
    localparam logic [3:0] KIND_CONTROL = 4'hB;

    // One input item as the sender drives it.
    typedef struct {
        logic       cmd;
        logic [1:0] size;
        logic [7:0] status;
        logic [7:0] d1;
        logic [7:0] d2;
        logic [3:0] tch;
    } midi_item_t;

    // One predicted gate level.
    typedef struct {
        logic [3:0] gate;
        logic [3:0] channel;
        logic [6:0] lvl;
        logic       last_flag;
    } gate_level_t;

    // Image of all configuration registers.
    typedef struct {
        logic [31:0] map [4];
        logic [1:0]  vel_mode;
        logic        mpe;
        logic        trig;
        logic [15:0] pulse;
    } reg_image_t;

    // ------------------------------------------------------------------------
    // Gate tracker: its own copy of the registers and of every gate entry,
    // updated at each accepted item, and the queue of levels still owed.
    // ------------------------------------------------------------------------
    class gate_tracker;
        logic [31:0] note_map [4];
        logic [1:0]  velocity_mode;
        logic        mpe_mode;
        logic        trig_mode;
        logic [15:0] pulse_ticks;

        logic        gate_open  [NUM_GATES][NUM_CHANNELS];
        logic [6:0]  gate_vel   [NUM_GATES][NUM_CHANNELS];
        logic [15:0] pulse_left [NUM_GATES][NUM_CHANNELS];

        gate_level_t pending_levels [$];
        int          errors;
        int          items_seen;
        int          levels_checked;

        function new();
            note_map[0]   = NOTE_MAP_0_3_RST;
            note_map[1]   = NOTE_MAP_4_7_RST;
            note_map[2]   = NOTE_MAP_8_11_RST;
            note_map[3]   = NOTE_MAP_12_15_RST;
            velocity_mode = VM_FIXED;
            mpe_mode      = 1'b0;
            trig_mode     = 1'b0;
            pulse_ticks   = PULSE_TICKS_RST;
            for (int g = 0; g < NUM_GATES; g++)
                for (int c = 0; c < NUM_CHANNELS; c++)
                begin
                    gate_open[g][c]  = 1'b0;
                    gate_vel[g][c]   = LEVEL_FULL;
                    pulse_left[g][c] = 16'd0;
                end
            errors         = 0;
            items_seen     = 0;
            levels_checked = 0;
        endfunction

        function void set_reg(input logic [CFG_INDEX_W-1:0] index,
                              input logic [CFG_DATA_W-1:0] value);
            case (index)
                REG_NOTE_MAP_0_3:   note_map[0]   = value;
                REG_NOTE_MAP_4_7:   note_map[1]   = value;
                REG_NOTE_MAP_8_11:  note_map[2]   = value;
                REG_NOTE_MAP_12_15: note_map[3]   = value;
                REG_VELOCITY_MODE:  velocity_mode = value[1:0];
                REG_MPE_MODE:       mpe_mode      = value[0];
                REG_TRIG_MODE:      trig_mode     = value[0];
                REG_PULSE_TICKS:    pulse_ticks   = value[15:0];
                default: ;
            endcase
        endfunction

        // A learned byte with its top bit set never matches.
        function bit note_hits(input int g, input logic [6:0] note);
            logic [7:0] learned;
            learned = note_map[g / 4][(g % 4) * 8 +: 8];
            return (learned[7] == 1'b0) && (learned[6:0] == note);
        endfunction

        function void record_item(input midi_item_t it);
            logic [3:0]  ch;
            logic [6:0]  note;
            logic [3:0]  kind;
            logic        pulse_on;
            logic        high;
            gate_level_t lv;
            items_seen++;
            if (it.cmd == 1'b0)
            begin
                ch   = mpe_mode ? it.status[3:0] : 4'd0;
                note = it.d1[6:0];
                kind = it.status[7:4];
                if (it.size < 2)
                    return;
                if (kind == KIND_NOTE_ON && it.d2 != 8'd0)
                begin
                    for (int g = 0; g < NUM_GATES; g++)
                        if (note_hits(g, note))
                        begin
                            gate_open[g][ch] = 1'b1;
                            if (velocity_mode == VM_NOTE_VEL)
                                gate_vel[g][ch] = it.d2[6:0];
                            pulse_left[g][ch] = pulse_ticks;
                        end
                end
                else if (kind == KIND_NOTE_OFF || kind == KIND_NOTE_ON)
                begin
                    for (int g = 0; g < NUM_GATES; g++)
                        if (note_hits(g, note))
                            gate_open[g][ch] = 1'b0;
                end
                else if (kind == KIND_AFTERTOUCH && velocity_mode == VM_PRESSURE)
                begin
                    for (int g = 0; g < NUM_GATES; g++)
                        if (note_hits(g, note))
                            gate_vel[g][ch] = it.d2[6:0];
                end
                else if (kind == KIND_PRESSURE && velocity_mode == VM_PRESSURE)
                begin
                    for (int g = 0; g < NUM_GATES; g++)
                        gate_vel[g][ch] = it.d1[6:0];
                end
                return;
            end
            if (!mpe_mode && it.tch != 4'd0)
                return;
            for (int g = 0; g < NUM_GATES; g++)
            begin
                pulse_on = (pulse_left[g][it.tch] != 16'd0);
                if (pulse_on)
                    pulse_left[g][it.tch] = pulse_left[g][it.tch] - 16'd1;
                high = pulse_on || (!trig_mode && gate_open[g][it.tch]);
                lv.gate      = 4'(g);
                lv.channel   = it.tch;
                lv.lvl       = !high ? 7'd0 :
                               (velocity_mode == VM_FIXED) ? LEVEL_FULL : gate_vel[g][it.tch];
                lv.last_flag = (g == NUM_GATES - 1);
                pending_levels.push_back(lv);
            end
        endfunction

        function void check_level(input logic [3:0] gate, input logic [3:0] channel,
                                  input logic [6:0] lvl, input logic last_flag);
            gate_level_t want;
            if (pending_levels.size() == 0)
            begin
                $error("unexpected level: gate_index %0d out_channel %0d level %0d",
                       gate, channel, lvl);
                errors++;
                return;
            end
            want = pending_levels.pop_front();
            levels_checked++;
            if (gate !== want.gate)
            begin
                $error("gate_index: expected %0d, actual %0d", want.gate, gate);
                errors++;
            end
            if (channel !== want.channel)
            begin
                $error("out_channel: expected %0d, actual %0d", want.channel, channel);
                errors++;
            end
            if (lvl !== want.lvl)
            begin
                $error("level: expected %0d, actual %0d", want.lvl, lvl);
                errors++;
            end
            if (last_flag !== want.last_flag)
            begin
                $error("last: expected %0d, actual %0d", want.last_flag, last_flag);
                errors++;
            end
        endfunction

        function int pending();
            return pending_levels.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block under test and its signals.
    // ------------------------------------------------------------------------
    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic                   cmd;
    logic [1:0]             msg_size;
    logic [7:0]             status_byte;
    logic [7:0]             data_one;
    logic [7:0]             data_two;
    logic [3:0]             tick_channel;
    logic                   out_valid;
    logic                   out_stall;
    logic [3:0]             gate_index;
    logic [3:0]             out_channel;
    logic [6:0]             level;
    logic                   last;

    midi_note_to_gate_converter i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .msg_size     (msg_size),
        .status_byte  (status_byte),
        .data_one     (data_one),
        .data_two     (data_two),
        .tick_channel (tick_channel),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .gate_index   (gate_index),
        .out_channel  (out_channel),
        .level        (level),
        .last         (last)
    );

    gate_tracker sb;
    reg_image_t  cur_cfg;

    // Idling bounds of both sides, changed per phase, and a request for one
    // long output hold that the receiver process picks up.
    int tx_max_wait   = 8;
    int rx_max_wait   = 8;
    int hold_request  = 0;
    int cycle_count   = 0;
    int setting_count = 0;

    // ------------------------------------------------------------------------
    // Clock and run limit.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Inputs change only by nonblocking assignment at the clock
    // edge, so the values read here are the ones the block sampled at this
    // edge. An item is taken when valid is high and stall is low.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        midi_item_t seen;
        if (rst_n === 1'b1)
        begin
            if (out_valid && !out_stall)
                sb.check_level(gate_index, out_channel, level, last);
            if (in_valid && !in_stall)
            begin
                seen.cmd    = cmd;
                seen.size   = msg_size;
                seen.status = status_byte;
                seen.d1     = data_one;
                seen.d2     = data_two;
                seen.tch    = tick_channel;
                sb.record_item(seen);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. Before each level it holds stall high for a random number of
    // cycles, then takes the level. A pending hold request replaces the
    // random draw with one long stretch, which backs the block up.
    // ------------------------------------------------------------------------
    initial
    begin
        int n;
        out_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_request > 0)
            begin
                n = hold_request;
                hold_request = 0;
            end
            else
                n = $urandom_range(0, rx_max_wait);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // ------------------------------------------------------------------------
    // Sender. Each item waits a random gap first; with no gap the next item
    // is driven at the clock edge at which the previous one was taken, so valid stays
    // high and is never lowered and raised in one step.
    // ------------------------------------------------------------------------
    task automatic offer(input midi_item_t it);
        int gap;
        gap = $urandom_range(0, tx_max_wait);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd          <= it.cmd;
        msg_size     <= it.size;
        status_byte  <= it.status;
        data_one     <= it.d1;
        data_two     <= it.d2;
        tick_channel <= it.tch;
        in_valid     <= 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    // Drop valid, let every owed level arrive, then let a trailing message
    // sweep finish before anything touches the registers.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        sb.set_reg(index, value);
    endtask

    // Writes every register; only called while the block is idle.
    task automatic apply_config(input reg_image_t c);
        write_reg(REG_NOTE_MAP_0_3,   c.map[0]);
        write_reg(REG_NOTE_MAP_4_7,   c.map[1]);
        write_reg(REG_NOTE_MAP_8_11,  c.map[2]);
        write_reg(REG_NOTE_MAP_12_15, c.map[3]);
        write_reg(REG_VELOCITY_MODE,  {30'd0, c.vel_mode});
        write_reg(REG_MPE_MODE,       {31'd0, c.mpe});
        write_reg(REG_TRIG_MODE,      {31'd0, c.trig});
        write_reg(REG_PULSE_TICKS,    {16'd0, c.pulse});
        cfg_wr_en <= 1'b0;
        cur_cfg = c;
        setting_count++;
    endtask

    function automatic reg_image_t reset_image();
        reg_image_t c;
        c.map[0]   = NOTE_MAP_0_3_RST;
        c.map[1]   = NOTE_MAP_4_7_RST;
        c.map[2]   = NOTE_MAP_8_11_RST;
        c.map[3]   = NOTE_MAP_12_15_RST;
        c.vel_mode = VM_FIXED;
        c.mpe      = 1'b0;
        c.trig     = 1'b0;
        c.pulse    = PULSE_TICKS_RST;
        return c;
    endfunction

    // Learned notes drawn from a narrow pool so that several gates often
    // share one note; some bytes have the top bit set and never match.
    function automatic logic [31:0] crowded_map();
        logic [31:0] m;
        for (int b = 0; b < 4; b++)
        begin
            case ($urandom_range(0, 9))
                7:       m[b * 8 +: 8] = 8'h80 | 8'($urandom_range(0, 127));
                8, 9:    m[b * 8 +: 8] = 8'($urandom_range(0, 255));
                default: m[b * 8 +: 8] = 8'd60 + 8'($urandom_range(0, 5));
            endcase
        end
        return m;
    endfunction

    function automatic midi_item_t make_msg(input logic [7:0] status, input logic [7:0] d1,
                                            input logic [7:0] d2, input logic [1:0] size);
        midi_item_t it;
        it.cmd    = 1'b0;
        it.size   = size;
        it.status = status;
        it.d1     = d1;
        it.d2     = d2;
        it.tch    = 4'($urandom_range(0, 15));
        return it;
    endfunction

    function automatic midi_item_t make_tick(input logic [3:0] ch);
        midi_item_t it;
        it.cmd    = 1'b1;
        it.size   = 2'($urandom_range(0, 3));
        it.status = 8'($urandom_range(0, 255));
        it.d1     = 8'($urandom_range(0, 255));
        it.d2     = 8'($urandom_range(0, 255));
        it.tch    = ch;
        return it;
    endfunction

    // Random item: mostly ticks on the busy channels and note traffic that
    // hits learned notes, the rest pure noise in every field.
    function automatic midi_item_t random_item();
        midi_item_t  it;
        int          pick;
        int          g;
        int          kind_pick;
        logic [3:0]  ch;
        logic [3:0]  kind;
        logic [7:0]  learned;
        it.cmd    = 1'($urandom_range(0, 1));
        it.size   = 2'($urandom_range(0, 3));
        it.status = 8'($urandom_range(0, 255));
        it.d1     = 8'($urandom_range(0, 255));
        it.d2     = 8'($urandom_range(0, 255));
        it.tch    = 4'($urandom_range(0, 15));
        pick      = $urandom_range(0, 99);
        ch        = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 3))
                                               : 4'($urandom_range(0, 15));
        if (pick < 35)
        begin
            it.cmd = 1'b1;
            if (cur_cfg.mpe)
                it.tch = ch;
            else
                it.tch = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'd0;
        end
        else if (pick < 82)
        begin
            it.cmd  = 1'b0;
            it.size = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 1))
                                                  : 2'($urandom_range(2, 3));
            kind_pick = $urandom_range(0, 99);
            if (kind_pick < 40)
                kind = KIND_NOTE_ON;
            else if (kind_pick < 60)
                kind = KIND_NOTE_OFF;
            else if (kind_pick < 75)
                kind = KIND_AFTERTOUCH;
            else if (kind_pick < 90)
                kind = KIND_PRESSURE;
            else
                kind = 4'($urandom_range(0, 15));
            it.status = {kind, ch};
            g = $urandom_range(0, NUM_GATES - 1);
            learned = cur_cfg.map[g / 4][(g % 4) * 8 +: 8];
            if ($urandom_range(0, 3) != 0)
                it.d1 = {1'($urandom_range(0, 1)), learned[6:0]};
            if ($urandom_range(0, 6) == 0)
                it.d2 = 8'd0;
        end
        return it;
    endfunction

    task automatic random_phase(input reg_image_t c, input int count,
                                input int tx_wait, input int rx_wait);
        apply_config(c);
        tx_max_wait = tx_wait;
        rx_max_wait = rx_wait;
        repeat (count) offer(random_item());
        settle();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        reg_image_t c;
        sb = new();
        rst_n        <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= REG_NOTE_MAP_0_3;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        cmd          <= 1'b0;
        msg_size     <= 2'd0;
        status_byte  <= 8'd0;
        data_one     <= 8'd0;
        data_two     <= 8'd0;
        tick_channel <= 4'd0;
        cur_cfg = reset_image();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset settings: fixed level, no MPE, gates held. The
        // reset note map puts notes 48 to 51 on gates 0 to 3.
        offer(make_msg({KIND_NOTE_ON, 4'd0}, 8'd48, 8'd100, 2'd3));
        offer(make_tick(4'd0));
        // A tick for another channel outside MPE is ignored.
        offer(make_tick(4'd3));
        // The message channel is forced to zero outside MPE.
        offer(make_msg({KIND_NOTE_ON, 4'd7}, 8'd49, 8'd1, 2'd2));
        offer(make_tick(4'd0));
        // Note-on with velocity zero closes like a note-off.
        offer(make_msg({KIND_NOTE_ON, 4'd0}, 8'd48, 8'd0, 2'd3));
        offer(make_msg({KIND_NOTE_OFF, 4'd0}, 8'd49, 8'd64, 2'd2));
        // Short messages and other kinds change nothing.
        offer(make_msg({KIND_NOTE_ON, 4'd0}, 8'd50, 8'd90, 2'd1));
        offer(make_msg({KIND_NOTE_ON, 4'd0}, 8'd51, 8'd90, 2'd0));
        offer(make_msg({KIND_CONTROL, 4'd0}, 8'd50, 8'd90, 2'd3));
        // Aftertouch outside velocity mode 2 is ignored.
        offer(make_msg({KIND_AFTERTOUCH, 4'd0}, 8'd48, 8'd5, 2'd3));
        offer(make_tick(4'd0));
        settle();

        // Directed: note velocity, MPE, trigger-only pulses of two ticks.
        c = reset_image();
        c.vel_mode = VM_NOTE_VEL;
        c.mpe      = 1'b1;
        c.trig     = 1'b1;
        c.pulse    = 16'd2;
        apply_config(c);
        // Velocity bytes above 127 are masked; 0x80 stores zero.
        offer(make_msg({KIND_NOTE_ON, 4'd5}, 8'd36, 8'hFF, 2'd3));
        offer(make_msg({KIND_NOTE_ON, 4'd5}, 8'd37, 8'h80, 2'd3));
        // The top bit of the note number is dropped.
        offer(make_msg({KIND_NOTE_ON, 4'd15}, 8'hA6, 8'h45, 2'd3));
        offer(make_tick(4'd5));
        offer(make_tick(4'd5));
        offer(make_tick(4'd5));
        offer(make_tick(4'd15));
        settle();

        // Directed: aftertouch and channel pressure set velocities.
        c.vel_mode = VM_PRESSURE;
        c.trig     = 1'b0;
        c.pulse    = 16'd1;
        apply_config(c);
        offer(make_msg({KIND_AFTERTOUCH, 4'd5}, 8'd37, 8'h9A, 2'd3));
        offer(make_msg({KIND_PRESSURE, 4'd15}, 8'hC5, 8'd0, 2'd2));
        offer(make_tick(4'd5));
        offer(make_tick(4'd15));
        offer(make_msg({KIND_NOTE_OFF, 4'd5}, 8'd36, 8'd0, 2'd3));
        offer(make_tick(4'd5));
        settle();

        // Random phase: crowded note map, note velocity, one-tick pulses.
        c.map[0]   = crowded_map();
        c.map[1]   = crowded_map();
        c.map[2]   = crowded_map();
        c.map[3]   = crowded_map();
        c.vel_mode = VM_NOTE_VEL;
        c.mpe      = 1'b1;
        c.trig     = 1'b0;
        c.pulse    = 16'd1;
        random_phase(c, 17, 8, 8);

        // Random phase at the extremes: all of the first four gates on note
        // zero, a fully random map, a map that never matches, the longest
        // pulse, pressure mode and trigger-only output.
        c.map[0]   = 32'h0000_0000;
        c.map[1]   = crowded_map();
        c.map[2]   = $urandom;
        c.map[3]   = 32'hFFFF_FFFF;
        c.vel_mode = VM_PRESSURE;
        c.mpe      = 1'b1;
        c.trig     = 1'b1;
        c.pulse    = 16'hFFFF;
        random_phase(c, 17, 8, 8);

        // Random phase with no idling on either side: velocity mode three
        // (stored velocities never change), no MPE, and no pulse at all.
        c.map[0]   = crowded_map();
        c.map[1]   = crowded_map();
        c.map[2]   = crowded_map();
        c.map[3]   = crowded_map();
        c.vel_mode = 2'd3;
        c.mpe      = 1'b0;
        c.trig     = 1'b0;
        c.pulse    = 16'd0;
        random_phase(c, 17, 0, 0);

        // Pressure phase: the receiver holds off for a long stretch while
        // the sender keeps offering ticks, so the sweep pauses with a level
        // parked in the output register and input stall stays high.
        c.vel_mode = VM_FIXED;
        c.mpe      = 1'b1;
        c.trig     = 1'b1;
        c.pulse    = 16'd3;
        apply_config(c);
        tx_max_wait  = 2;
        rx_max_wait  = 8;
        hold_request = HOLD_CYCLES;
        repeat (4) offer(random_item());
        repeat (8) offer(make_tick(4'($urandom_range(0, 3))));
        repeat (10) offer(random_item());
        settle();

        // Random phase: pressure mode with held gates and short pulses.
        c.map[0]   = crowded_map();
        c.map[1]   = crowded_map();
        c.vel_mode = VM_PRESSURE;
        c.mpe      = 1'b1;
        c.trig     = 1'b0;
        c.pulse    = 16'($urandom_range(1, 6));
        random_phase(c, 17, 8, 8);

        // Random phase: note velocity, no MPE, trigger-only output.
        c.map[2]   = crowded_map();
        c.map[3]   = crowded_map();
        c.vel_mode = VM_NOTE_VEL;
        c.mpe      = 1'b0;
        c.trig     = 1'b1;
        c.pulse    = 16'd5;
        random_phase(c, 17, 8, 4);

        $display("Run summary: %0d items taken, %0d levels compared, %0d register settings.",
                 sb.items_seen, sb.levels_checked, setting_count);
        $display("Covered directed corner cases, random MIDI traffic,");
        $display("a gap-free burst and a long output hold.");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule : tb
`default_nettype wire
